/* rtl/core/bitmap_extent_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap extent allocator
// Shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_EXTENT_ALLOCATOR_ASSERT_SVH
`define BITMAP_EXTENT_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BEA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bitmap extent allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bitmap extent allocator: next-cycle check failed");

`endif

/* rtl/core/bea_pkg.sv */
// ----------------------------------------------------------------------------
// bea_pkg
// Shared types and constants of the bitmap extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bea_pkg;

  localparam int unsigned ClustersDef  = 4096;
  localparam int unsigned FragmentsDef = 32;

  localparam int unsigned CsW    = 17;
  localparam int unsigned DsW    = 32;
  localparam int unsigned BytesW = 32;
  localparam int unsigned NeedW  = 33;
  localparam int unsigned AddrW  = 33;

  localparam logic [CsW-1:0] CsReset = CsW'(512);

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FRAGLIM = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_CLUSTER_SIZE = 2'd0,
    REG_DATA_START   = 2'd1,
    REG_RSVD2        = 2'd2,
    REG_RSVD3        = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_EV,
    S_REL,
    S_MUL,
    S_OUT
  } state_e;

  // Divider start request and its answer.
  typedef struct packed {
    logic              start;
    logic [BytesW-1:0] dividend;
    logic [CsW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NeedW-1:0] need;
  } div_res_t;

endpackage

`default_nettype wire

/* rtl/core/bea_div.sv */
// ----------------------------------------------------------------------------
// bea_div
// Restoring divider, one quotient bit per cycle, rounding the quotient up.
// ----------------------------------------------------------------------------
`default_nettype none

module bea_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bea_pkg::div_req_t req_i,
  output bea_pkg::div_res_t      res_o
);
  import bea_pkg::*;

  localparam int unsigned CntW = $clog2(BytesW + 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [BytesW-1:0] quo_q, quo_d;
  logic [CsW:0]      rem_q, rem_d;
  logic [CsW-1:0]    dvs_q, dvs_d;
  logic              done_q, done_d;
  logic [CsW:0]      rem_sh;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // One trial subtraction per cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    rem_sh = {rem_q[CsW-1:0], quo_q[BytesW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[BytesW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[BytesW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(BytesW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.need = NeedW'(quo_q) + NeedW'(rem_q != '0);

endmodule

`default_nettype wire

/* rtl/core/bea_map.sv */
// ----------------------------------------------------------------------------
// bea_map
// Cluster used map: one bit per cluster, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bea_map #(
  parameter int unsigned CLUSTERS = bea_pkg::ClustersDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [$clog2(CLUSTERS)-1:0] wr_addr_i,
  input  wire logic                        wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [$clog2(CLUSTERS)-1:0] rd_addr_i,
  output logic                             rd_data_o
);

  logic mem_q [CLUSTERS];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bitmap_extent_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_extent_allocator
// First-fit cluster allocator over a used/free bit map.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  input    | in_valid_i / in_stall_o   | cmd, byte_size, extent_start/count
//  result   | out_valid_o / out_stall_i | fits, frag_index/address/count, ...
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  After reset a clearing pass zeroes the map; no item is taken
//  meanwhile. Query and allocate run the divider, then walk the map
//  cluster by cluster (read, then evaluate); a zero-cluster allocate
//  skips the walk. Release frees up to extent_count clusters from
//  extent_start, stopping at the map's end. Each emitted extent passes
//  multiply, then load, and waits while a result is held under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_extent_allocator #(
  parameter int unsigned CLUSTERS  = bea_pkg::ClustersDef,
  parameter int unsigned FRAGMENTS = bea_pkg::FragmentsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] byte_size_i,
  input  wire logic [11:0] extent_start_i,
  input  wire logic [12:0] extent_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             fits_o,
  output logic [11:0]      frag_index_o,
  output logic [32:0]      frag_address_o,
  output logic [12:0]      frag_count_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import bea_pkg::*;

  localparam int unsigned AW  = $clog2(CLUSTERS);
  localparam int unsigned CW  = $clog2(CLUSTERS + 1);
  localparam int unsigned FW  = $clog2(FRAGMENTS + 1);
  localparam int unsigned IW  = (AW > 12) ? AW : 12;
  localparam int unsigned RW  = IW + 2;

  // Configuration registers.
  logic [CsW-1:0] cs_q;
  logic [DsW-1:0] ds_q;
  logic [CsW-1:0] cs_eff;

  assign cfg_ready_o = 1'b1;
  assign cs_eff      = (cs_q == '0) ? CsW'(1) : cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= CsReset;
      ds_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_index_i))
        REG_CLUSTER_SIZE: cs_q <= cfg_data_i[CsW-1:0];
        REG_DATA_START:   ds_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [12:0]       rcnt_q, rcnt_d;
  logic [RW-1:0]     ridx_q, ridx_d;
  logic [12:0]       j_q, j_d;
  logic [NeedW-1:0]  need_q, need_d;
  logic [AW:0]       i_q, i_d;
  logic [CW-1:0]     free_q, free_d;
  logic [CW-1:0]     done_q, done_d;
  logic [FW-1:0]     nfrag_q, nfrag_d;
  logic              open_q, open_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pstart_q, pstart_d;
  logic [CW-1:0]     pcnt_q, pcnt_d;
  status_e           st_q, st_d;
  logic              e_zero_q, e_zero_d;
  logic              e_fits_q, e_fits_d;
  logic              e_last_q, e_last_d;
  logic              e_ret_q, e_ret_d;
  logic [AddrW-1:0]  prod_q, prod_d;

  // Output register.
  logic              ov_q;
  logic              o_fits_q;
  logic [11:0]       o_idx_q;
  logic [32:0]       o_addr_q;
  logic [12:0]       o_cnt_q;
  logic [1:0]        o_st_q;
  logic              o_last_q;
  logic              out_load;
  logic              out_free;

  // Map and divider hookup.
  logic          wr_en, wr_data, rd_en, rd_data;
  logic [AW-1:0] wr_addr, rd_addr;
  div_req_t      div_req;
  div_res_t      div_res;

  bea_map #(
    .CLUSTERS (CLUSTERS)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bea_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      i_q     <= '0;
      open_q  <= 1'b0;
      pend_q  <= 1'b0;
      nfrag_q <= '0;
      e_ret_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      open_q  <= open_d;
      pend_q  <= pend_d;
      nfrag_q <= nfrag_d;
      e_ret_q <= e_ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    bytes_q  <= bytes_d;
    rcnt_q   <= rcnt_d;
    ridx_q   <= ridx_d;
    j_q      <= j_d;
    need_q   <= need_d;
    free_q   <= free_d;
    done_q   <= done_d;
    pstart_q <= pstart_d;
    pcnt_q   <= pcnt_d;
    st_q     <= st_d;
    e_zero_q <= e_zero_d;
    e_fits_q <= e_fits_d;
    e_last_q <= e_last_d;
    prod_q   <= prod_d;
  end

  // Next state and datapath control.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    bytes_d  = bytes_q;
    rcnt_d   = rcnt_q;
    ridx_d   = ridx_q;
    j_d      = j_q;
    need_d   = need_q;
    i_d      = i_q;
    free_d   = free_q;
    done_d   = done_q;
    nfrag_d  = nfrag_q;
    open_d   = open_q;
    pend_d   = pend_q;
    pstart_d = pstart_q;
    pcnt_d   = pcnt_q;
    st_d     = st_q;
    e_zero_d = e_zero_q;
    e_fits_d = e_fits_q;
    e_last_d = e_last_q;
    e_ret_d  = e_ret_q;
    prod_d   = prod_q;
    wr_en    = 1'b0;
    wr_addr  = i_q[AW-1:0];
    wr_data  = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = i_q[AW-1:0];
    out_load = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = bytes_q;
    div_req.divisor  = cs_eff;

    case (state_q)
      // Zero the map once after reset.
      S_CLEAR: begin
        wr_en = 1'b1;
        i_d   = i_q + 1'b1;
        if (i_q == (AW+1)'(CLUSTERS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_e'(cmd_i);
          bytes_d  = byte_size_i;
          rcnt_d   = extent_count_i;
          ridx_d   = RW'(extent_start_i);
          j_d      = '0;
          e_zero_d = 1'b1;
          e_fits_d = 1'b0;
          e_last_d = 1'b1;
          e_ret_d  = 1'b0;
          st_d     = ST_OK;
          case (cmd_e'(cmd_i))
            CMD_QUERY, CMD_ALLOC: begin
              div_req.start    = 1'b1;
              div_req.dividend = byte_size_i;
              state_d          = S_DIV;
            end
            CMD_RELEASE: state_d = S_REL;
            default:     state_d = S_OUT;
          endcase
        end
      end

      S_DIV: begin
        if (div_res.done) begin
          need_d  = div_res.need;
          i_d     = '0;
          free_d  = '0;
          done_d  = '0;
          nfrag_d = '0;
          open_d  = 1'b0;
          pend_d  = 1'b0;
          if (cmd_q == CMD_ALLOC && div_res.need == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end

      // Read one map bit, or finish the walk.
      S_RD: begin
        if (cmd_q == CMD_QUERY) begin
          if (i_q == (AW+1)'(CLUSTERS)) begin
            e_fits_d = (need_q <= NeedW'(free_q));
            state_d  = S_OUT;
          end else begin
            rd_en   = 1'b1;
            state_d = S_EV;
          end
        end else if (i_q == (AW+1)'(CLUSTERS) || NeedW'(done_q) == need_q) begin
          if (NeedW'(done_q) != need_q) begin
            st_d = ST_NOSPACE;
          end
          e_last_d = 1'b1;
          e_ret_d  = 1'b0;
          e_zero_d = !pend_q;
          state_d  = pend_q ? S_MUL : S_OUT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_EV;
        end
      end

      // Act on the bit just read.
      S_EV: begin
        if (cmd_q == CMD_QUERY) begin
          if (!rd_data) begin
            free_d = free_q + 1'b1;
          end
          i_d     = i_q + 1'b1;
          state_d = S_RD;
        end else if (rd_data) begin
          open_d  = 1'b0;
          i_d     = i_q + 1'b1;
          state_d = S_RD;
        end else if (!open_q && nfrag_q == FW'(FRAGMENTS)) begin
          st_d     = ST_FRAGLIM;
          e_last_d = 1'b1;
          e_ret_d  = 1'b0;
          e_zero_d = !pend_q;
          state_d  = pend_q ? S_MUL : S_OUT;
        end else if (!open_q && pend_q) begin
          // Hand out the previous extent before opening a new one.
          pend_d   = 1'b0;
          e_last_d = 1'b0;
          e_ret_d  = 1'b1;
          e_zero_d = 1'b0;
          state_d  = S_MUL;
        end else begin
          if (!open_q) begin
            pstart_d = IW'(i_q[AW-1:0]);
            pcnt_d   = CW'(1);
            nfrag_d  = nfrag_q + 1'b1;
            open_d   = 1'b1;
            pend_d   = 1'b1;
          end else begin
            pcnt_d = pcnt_q + 1'b1;
          end
          wr_en   = 1'b1;
          wr_data = 1'b1;
          done_d  = done_q + 1'b1;
          i_d     = i_q + 1'b1;
          state_d = S_RD;
        end
      end

      // Free one cluster per cycle.
      S_REL: begin
        if (j_q == rcnt_q || ridx_q >= RW'(CLUSTERS)) begin
          state_d = S_OUT;
        end else begin
          wr_en   = 1'b1;
          wr_addr = ridx_q[AW-1:0];
          j_d     = j_q + 1'b1;
          ridx_d  = ridx_q + 1'b1;
        end
      end

      S_MUL: begin
        prod_d  = AddrW'(pstart_q * cs_eff);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = e_ret_q ? S_EV : S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Result register: a held result is replaced once it has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_fits_q <= e_fits_q;
      o_st_q   <= e_last_q ? st_q : ST_OK;
      o_last_q <= e_last_q;
      if (e_zero_q) begin
        o_idx_q  <= '0;
        o_addr_q <= '0;
        o_cnt_q  <= '0;
      end else begin
        o_idx_q  <= pstart_q[11:0];
        o_addr_q <= AddrW'({1'b0, ds_q} + prod_q);
        o_cnt_q  <= 13'(pcnt_q);
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign fits_o         = o_fits_q;
  assign frag_index_o   = o_idx_q;
  assign frag_address_o = o_addr_q;
  assign frag_count_o   = o_cnt_q;
  assign status_o       = o_st_q;
  assign last_o         = o_last_q;

endmodule

`default_nettype wire

/* rtl/core/bea_checker.sv */
// ----------------------------------------------------------------------------
// bea_checker
// Port-level checks on the result stream of the bitmap extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_extent_allocator_assert.svh"

module bea_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        fits_o,
  input wire logic [32:0] frag_address_o,
  input wire logic [12:0] frag_count_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_o
);
  import bea_pkg::*;

  // A stalled transfer keeps its address.
  `BEA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(frag_address_o))

  // Only the final result of a command carries a failure status.
  `BEA_ASSERT_SAME(a_status_last, clk_i, rst_ni, out_valid_o && status_o != ST_OK, last_o)

  // A query answer is a lone, empty result.
  `BEA_ASSERT_SAME(a_fits_alone, clk_i, rst_ni, out_valid_o && fits_o, last_o && frag_count_o == '0 && status_o == ST_OK)

  // Intermediate extents are never empty.
  `BEA_ASSERT_SAME(a_mid_nonempty, clk_i, rst_ni, out_valid_o && !last_o, frag_count_o != '0)

endmodule

bind bitmap_extent_allocator bea_checker u_bea_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .fits_o         (fits_o),
  .frag_address_o (frag_address_o),
  .frag_count_o   (frag_count_o),
  .status_o       (status_o),
  .last_o         (last_o)
);

`default_nettype wire
